// File: hdl/lpfp_pkg.sv
package lpfp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LengthW = 16;
  localparam int unsigned TdataW  = 7 * ByteW;

  // Configuration register indexes
  localparam logic [0:0] CfgMarkerFirst  = 1'b0;
  localparam logic [0:0] CfgMarkerSecond = 1'b1;

  localparam logic [ByteW-1:0] MarkerFirstRst  = 8'h5A;
  localparam logic [ByteW-1:0] MarkerSecondRst = 8'h9E;

  typedef struct packed {
    logic [ByteW-1:0]   payload_byte;
    logic [LengthW-1:0] frame_length;
    logic [ByteW-1:0]   frame_command;
    logic [ByteW-1:0]   frame_kind;
    logic [ByteW-1:0]   frame_flag;
    logic [ByteW-1:0]   frame_checksum;
  } frame_data_t;

  typedef struct packed {
    frame_data_t data;
    logic        payload_valid;
    logic        frame_last;
  } frame_res_t;

endpackage

// File: hdl/lpfp_core.sv
module lpfp_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_index_i,
  input  logic [lpfp_pkg::ByteW-1:0] cfg_data_i,
  input  logic                      step_i,
  input  logic [lpfp_pkg::ByteW-1:0] rx_byte_i,
  output logic                      res_valid_o,
  output lpfp_pkg::frame_res_t      res_o
);
  import lpfp_pkg::*;

  typedef enum logic [8:0] {
    PhHunt1    = 9'b000000001,
    PhHunt2    = 9'b000000010,
    PhChecksum = 9'b000000100,
    PhFlag     = 9'b000001000,
    PhKind     = 9'b000010000,
    PhCommand  = 9'b000100000,
    PhLenHi    = 9'b001000000,
    PhLenLo    = 9'b010000000,
    PhPayload  = 9'b100000000
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [ByteW-1:0]   marker_first_q, marker_second_q;
  logic [ByteW-1:0]   checksum_q, flag_q, kind_q, command_q;
  logic [LengthW-1:0] length_q;
  logic [LengthW-1:0] seen_q, seen_d;
  logic [LengthW-1:0] length_full;
  logic [LengthW-1:0] seen_inc;

  assign length_full = {length_q[LengthW-1:ByteW], rx_byte_i};
  assign seen_inc    = seen_q + LengthW'(1);

  always_comb begin
    phase_d     = phase_q;
    seen_d      = seen_q;
    res_valid_o = 1'b0;
    res_o.data.frame_checksum = checksum_q;
    res_o.data.frame_flag     = flag_q;
    res_o.data.frame_kind     = kind_q;
    res_o.data.frame_command  = command_q;
    res_o.data.frame_length   = length_q;
    res_o.data.payload_byte   = rx_byte_i;
    res_o.payload_valid       = 1'b1;
    res_o.frame_last          = 1'b1;
    unique case (phase_q)
      PhHunt1: begin
        if (rx_byte_i == marker_first_q) phase_d = PhHunt2;
      end
      PhHunt2: begin
        // second marker tested first; a repeated first marker keeps waiting
        priority if (rx_byte_i == marker_second_q) phase_d = PhChecksum;
        else if (rx_byte_i == marker_first_q) phase_d = PhHunt2;
        else phase_d = PhHunt1;
      end
      PhChecksum: phase_d = PhFlag;
      PhFlag:     phase_d = PhKind;
      PhKind:     phase_d = PhCommand;
      PhCommand:  phase_d = PhLenHi;
      PhLenHi:    phase_d = PhLenLo;
      PhLenLo: begin
        seen_d = '0;
        res_o.data.frame_length = length_full;
        res_o.data.payload_byte = '0;
        res_o.payload_valid     = 1'b0;
        if (length_full == '0) begin
          res_valid_o = step_i;
          phase_d     = PhHunt1;
        end else begin
          phase_d = PhPayload;
        end
      end
      PhPayload: begin
        res_valid_o = step_i;
        seen_d      = seen_inc;
        // seen never passes length, so equality marks the final byte
        res_o.frame_last = (seen_inc == length_q);
        if (seen_inc == length_q) phase_d = PhHunt1;
      end
      default: phase_d = PhHunt1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PhHunt1;
      seen_q          <= '0;
      marker_first_q  <= MarkerFirstRst;
      marker_second_q <= MarkerSecondRst;
    end else begin
      if (step_i) begin
        phase_q <= phase_d;
        seen_q  <= seen_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgMarkerFirst:  marker_first_q  <= cfg_data_i;
          CfgMarkerSecond: marker_second_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // header fields are always written before the frame uses them
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      if (phase_q == PhChecksum) checksum_q <= rx_byte_i;
      if (phase_q == PhFlag)     flag_q     <= rx_byte_i;
      if (phase_q == PhKind)     kind_q     <= rx_byte_i;
      if (phase_q == PhCommand)  command_q  <= rx_byte_i;
      if (phase_q == PhLenHi)    length_q   <= {rx_byte_i, ByteW'(0)};
      if (phase_q == PhLenLo)    length_q   <= length_full;
    end
  end

endmodule

// File: hdl/lpfp_out_buf.sv
module lpfp_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lpfp_pkg::frame_res_t in_res_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lpfp_pkg::frame_res_t out_res_o
);
  import lpfp_pkg::*;

  logic       out_valid_q, skid_valid_q;
  frame_res_t out_q, skid_q;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      // skid entry drains first; input is held off while it is full
      out_valid_q  <= skid_valid_q || in_valid_i;
      skid_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : in_res_i;
    end else if (in_valid_i && in_ready_o) begin
      skid_q <= in_res_i;
    end
  end

endmodule

// File: hdl/length_prefixed_frame_parser.sv
// Length-prefixed frame parser.
// Input stream (s_axis_*): one received byte per request. The parser hunts
// for the two-byte start marker, then takes checksum, flag, type, command and
// a big-endian 16-bit length. Each payload byte leaves as one request on the
// m_axis_* stream carrying all header fields; tlast marks the final byte.
// A zero-length frame gives one request with tuser (payload valid) low.
// Header and marker bytes give no output.
// Config channel (cfg_*): index 0 = first marker byte, 1 = second; always
// ready, write only while the block is idle.
// Throughput: one byte per cycle while s_axis_tready is high; the phase register advances on each accepted byte.
// Output: each result is registered in the output stage, or in the skid entry while the receiver stalls.
// Receiver stall: a two-entry output stage (register plus skid) absorbs one
// extra request, then s_axis_tready drops until the receiver takes data.
// Reset: markers return to 0x5A / 0x9E, the parser returns to hunting and
// both output entries are emptied.
module length_prefixed_frame_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [0:0]                  cfg_index_i,
  input  logic [lpfp_pkg::ByteW-1:0]  cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [lpfp_pkg::ByteW-1:0]  s_axis_tdata,  // rx_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // frame_checksum, frame_flag, frame_kind, frame_command, frame_length,
  // payload_byte
  output logic [lpfp_pkg::TdataW-1:0] m_axis_tdata,
  output logic [0:0]                  m_axis_tuser,  // payload_valid
  output logic                        m_axis_tlast   // frame_last
);
  import lpfp_pkg::*;

  logic       step;
  logic       res_valid;
  frame_res_t res, out_res;

  assign cfg_ready_o = 1'b1;
  assign step        = s_axis_tvalid && s_axis_tready;

  lpfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .rx_byte_i   (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lpfp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (s_axis_tready),
    .in_res_i    (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata = out_res.data;
  assign m_axis_tuser = out_res.payload_valid;
  assign m_axis_tlast = out_res.frame_last;

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpfp_pkg::*;

  typedef enum logic [3:0] {
    PhHunt1, PhHunt2, PhChecksum, PhFlag, PhKind, PhCommand, PhLenHi, PhLenLo, PhPayload
  } parse_phase_e;

  typedef struct packed {
    logic [ByteW-1:0] rx;
    logic             typed;    // expectation taken from this row, not the predictor
    logic             has_res;
    frame_res_t       res;
  } stim_row_t;

  localparam frame_res_t NoBeat = '0;
  // zero-length frame from the directed script: cks FF, flag 00, kind A5, cmd 3C
  localparam frame_res_t ZeroLenBeat = '{
    data: '{payload_byte: 8'h00, frame_length: 16'h0000, frame_command: 8'h3C,
            frame_kind: 8'hA5, frame_flag: 8'h00, frame_checksum: 8'hFF},
    payload_valid: 1'b0, frame_last: 1'b1};

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [0:0]         cfg_index_i = CfgMarkerFirst;
  logic [ByteW-1:0]   cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [ByteW-1:0]   s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b1;
  logic [TdataW-1:0]  m_axis_tdata;
  logic [0:0]         m_axis_tuser;
  logic               m_axis_tlast;

  // travel with each byte request, read back when it is accepted
  logic               row_typed = 1'b0;
  logic               row_has = 1'b0;
  frame_res_t         row_res = '0;

  // parser image
  parse_phase_e       phase = PhHunt1;
  logic [ByteW-1:0]   mark_a = MarkerFirstRst;
  logic [ByteW-1:0]   mark_b = MarkerSecondRst;
  logic [ByteW-1:0]   hold_cks = '0;
  logic [ByteW-1:0]   hold_flag = '0;
  logic [ByteW-1:0]   hold_kind = '0;
  logic [ByteW-1:0]   hold_cmd = '0;
  logic [LengthW-1:0] hold_len = '0;
  logic [LengthW-1:0] seen_cnt = '0;

  frame_res_t         due_beats[$];
  int unsigned        mismatch_cnt = 0;
  int unsigned        sent_cnt = 0;
  int unsigned        burst_left = 0;
  stim_row_t          script [0:22];

  length_prefixed_frame_parser dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void clear_hold();
    phase = PhHunt1;
    hold_cks = '0;
    hold_flag = '0;
    hold_kind = '0;
    hold_cmd = '0;
    hold_len = '0;
    seen_cnt = '0;
  endfunction

  // advances the parser image by one byte; returns 1 when a beat leaves
  function automatic bit parse_byte(input logic [ByteW-1:0] b, output frame_res_t beat);
    beat = '0;
    beat.data.frame_checksum = hold_cks;
    beat.data.frame_flag = hold_flag;
    beat.data.frame_kind = hold_kind;
    beat.data.frame_command = hold_cmd;
    beat.data.frame_length = hold_len;
    parse_byte = 1'b0;
    case (phase)
      PhHunt1: begin
        if (b == mark_a) phase = PhHunt2;
        else clear_hold();
      end
      PhHunt2: begin
        // second marker wins when both registers match
        if (b == mark_b) phase = PhChecksum;
        else if (b != mark_a) clear_hold();
      end
      PhChecksum: begin
        hold_cks = b;
        phase = PhFlag;
      end
      PhFlag: begin
        hold_flag = b;
        phase = PhKind;
      end
      PhKind: begin
        hold_kind = b;
        phase = PhCommand;
      end
      PhCommand: begin
        hold_cmd = b;
        phase = PhLenHi;
      end
      PhLenHi: begin
        hold_len = {b, 8'h00};
        phase = PhLenLo;
      end
      PhLenLo: begin
        hold_len = hold_len | LengthW'(b);
        if (hold_len != '0) begin
          seen_cnt = '0;
          phase = PhPayload;
        end else begin
          beat.data.frame_length = '0;
          beat.frame_last = 1'b1;
          parse_byte = 1'b1;
          clear_hold();
        end
      end
      PhPayload: begin
        seen_cnt = seen_cnt + 1'b1;
        beat.data.payload_byte = b;
        beat.payload_valid = 1'b1;
        beat.frame_last = (seen_cnt >= hold_len);
        parse_byte = 1'b1;
        if (beat.frame_last) clear_hold();
      end
      default: clear_hold();
    endcase
  endfunction

  task automatic check_field(input string name, input logic [LengthW-1:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    frame_res_t want, got, pred;
    bit         fires;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.data = m_axis_tdata;
        got.payload_valid = m_axis_tuser[0];
        got.frame_last = m_axis_tlast;
        if (due_beats.size() == 0) begin
          $error("output request with nothing expected: tdata %0h", m_axis_tdata);
          mismatch_cnt++;
        end else begin
          want = due_beats.pop_front();
          check_field("frame_checksum", want.data.frame_checksum, got.data.frame_checksum);
          check_field("frame_flag", want.data.frame_flag, got.data.frame_flag);
          check_field("frame_kind", want.data.frame_kind, got.data.frame_kind);
          check_field("frame_command", want.data.frame_command, got.data.frame_command);
          check_field("frame_length", want.data.frame_length, got.data.frame_length);
          check_field("payload_byte", want.data.payload_byte, got.data.payload_byte);
          check_field("payload_valid", want.payload_valid, got.payload_valid);
          check_field("frame_last", want.frame_last, got.frame_last);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        fires = parse_byte(s_axis_tdata, pred);
        if (row_typed) begin
          fires = row_has;
          pred = row_res;
        end
        if (fires) due_beats = {due_beats, pred};
      end
    end
  end

  // receiver: alternates between free flow, random stalls and a fixed duty pattern
  initial begin : rx_stall
    int unsigned mode, span, tick;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(posedge clk_i);
        tick++;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= ($urandom_range(0, 1) != 0);
          default: m_axis_tready <= ((tick % 7) >= 3);
        endcase
      end
    end
  end

  // one byte request; called on a clock edge, returns on the accepting edge
  task automatic send_rx(input logic [ByteW-1:0] b, input bit typed = 1'b0,
                         input bit has_res = 1'b0, input frame_res_t res = '0);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    s_axis_tdata <= b;
    s_axis_tvalid <= 1'b1;
    row_typed <= typed;
    row_has <= has_res;
    row_res <= res;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    sent_cnt++;
  endtask

  // hold the sender until every expected beat is out and the parser is quiet
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (due_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_markers(input logic [ByteW-1:0] a, input logic [ByteW-1:0] b);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgMarkerFirst;
    cfg_data_i <= a;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CfgMarkerSecond;
    cfg_data_i <= b;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mark_a = a;
    mark_b = b;
  endtask

  function automatic logic [ByteW-1:0] pick_other(input logic [ByteW-1:0] a, b);
    logic [ByteW-1:0] x;
    do x = ByteW'($urandom); while (x == a || x == b);
    return x;
  endfunction

  task automatic send_frame(input logic [LengthW-1:0] len);
    logic [ByteW-1:0] x;
    send_rx(mark_a);
    if (mark_a != mark_b && $urandom_range(0, 4) == 0) send_rx(mark_a);
    send_rx(mark_b);
    repeat (4) send_rx(ByteW'($urandom));  // checksum, flag, kind, command
    send_rx(len[15:8]);
    send_rx(len[7:0]);
    repeat (len) begin
      case ($urandom_range(0, 7))
        0: x = mark_a;
        1: x = mark_b;
        default: x = ByteW'($urandom);
      endcase
      send_rx(x);
    end
  endtask

  task automatic run_mix(input int unsigned n);
    int unsigned stop_at;
    stop_at = sent_cnt + n;
    while (sent_cnt < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          if ($urandom_range(0, 39) == 0) send_frame(LengthW'($urandom_range(256, 300)));
          else if ($urandom_range(0, 5) == 0) send_frame('0);
          else send_frame(LengthW'($urandom_range(1, 10)));
        end
        6, 7: repeat ($urandom_range(1, 4)) send_rx(pick_other(mark_a, mark_a));
        8: begin
          // first marker then a byte that is neither marker
          send_rx(mark_a);
          send_rx(pick_other(mark_a, mark_b));
        end
        default: repeat ($urandom_range(1, 3)) send_rx(ByteW'($urandom));
      endcase
    end
  endtask

  initial begin : stimulus
    script = '{
      '{8'h00, 1'b1, 1'b0, NoBeat},        // noise while hunting
      '{8'hFF, 1'b1, 1'b0, NoBeat},
      '{8'h5A, 1'b0, 1'b0, NoBeat},
      '{8'h5A, 1'b0, 1'b0, NoBeat},        // repeated first marker
      '{8'h9E, 1'b0, 1'b0, NoBeat},
      '{8'hFF, 1'b0, 1'b0, NoBeat},
      '{8'h00, 1'b0, 1'b0, NoBeat},
      '{8'hA5, 1'b0, 1'b0, NoBeat},
      '{8'h3C, 1'b0, 1'b0, NoBeat},
      '{8'h00, 1'b0, 1'b0, NoBeat},
      '{8'h00, 1'b1, 1'b1, ZeroLenBeat},   // zero-length frame
      '{8'h5A, 1'b0, 1'b0, NoBeat},
      '{8'h11, 1'b1, 1'b0, NoBeat},        // wrong second marker
      '{8'h5A, 1'b0, 1'b0, NoBeat},
      '{8'h9E, 1'b0, 1'b0, NoBeat},
      '{8'h01, 1'b0, 1'b0, NoBeat},
      '{8'h02, 1'b0, 1'b0, NoBeat},
      '{8'h03, 1'b0, 1'b0, NoBeat},
      '{8'h04, 1'b0, 1'b0, NoBeat},
      '{8'h00, 1'b0, 1'b0, NoBeat},
      '{8'h02, 1'b0, 1'b0, NoBeat},
      '{8'h5A, 1'b0, 1'b0, NoBeat},        // markers inside the payload
      '{8'h9E, 1'b0, 1'b0, NoBeat}
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (script[i]) send_rx(script[i].rx, script[i].typed, script[i].has_res, script[i].res);
    run_mix(90);
    drain();
    set_markers(8'h00, 8'hFF);
    run_mix(90);
    drain();
    set_markers(8'hFF, 8'h00);
    run_mix(90);
    drain();
    set_markers(8'h77, 8'h77);
    run_mix(80);
    drain();
    set_markers(ByteW'($urandom), ByteW'($urandom));
    run_mix(80);
    drain();
    set_markers(MarkerFirstRst, MarkerSecondRst);
    // length with both bytes set
    send_frame(16'h0102);
    run_mix(30);
    drain();
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
hdl/lpfp_pkg.sv
hdl/lpfp_core.sv
hdl/lpfp_out_buf.sv
hdl/length_prefixed_frame_parser.sv
tb/tb.sv
